FILE: hw/rtl/mmh3_pkg.sv
// Shared types, constants and helper functions of the MurmurHash3 key hash.
`default_nettype none
package mmh3_pkg;

  // Width of the running key length counter.
  localparam int unsigned LengthBits = 32;

  localparam logic [31:0] SeedReset = 32'h238F13AF;
  localparam logic [31:0] MixC1     = 32'hcc9e2d51;
  localparam logic [31:0] MixC2     = 32'h1b873593;
  localparam logic [31:0] MixC3     = 32'he6546b64;
  localparam logic [31:0] FinC1     = 32'h85ebca6b;
  localparam logic [31:0] FinC2     = 32'hc2b2ae35;

  // Byte count of a full word.
  localparam logic [2:0] FullCount = 3'd4;

  // One classified key word after the first multiply.
  typedef struct packed {
    logic [31:0] k1;
    logic [2:0]  count;
    logic        last;
  } mmh3_entry_t;

  // Fill status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } mmh3_q_stat_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mmh3_front.sv
// Front part: accepts key words, classifies the byte count and does the first multiply.
`default_nettype none
module mmh3_front import mmh3_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [31:0]  data_word_i,
  input  wire logic [2:0]   byte_count_i,
  input  wire logic         last_i,
  input  wire logic         push,
  output logic              full,
  input  wire mmh3_q_stat_t q_stat_i,
  output logic              q_push_o,
  output mmh3_entry_t       q_entry_o
);

  logic        valid_q, valid_d;
  mmh3_entry_t entry_q, entry_d;
  logic        accept;
  logic [2:0]  count;
  logic [31:0] mask;

  // The stage holds its word until the queue has room.
  assign q_push_o  = valid_q && !q_stat_i.full;
  assign full      = valid_q && q_stat_i.full;
  assign accept    = push && !full;
  assign q_entry_o = entry_q;

  // A non-last word always counts as a full word, and counts above four saturate.
  always_comb begin
    if (!last_i || (byte_count_i inside {[3'd4:3'd7]})) begin
      count = FullCount;
    end else begin
      count = byte_count_i;
    end
    case (count)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    entry_d.k1    = (data_word_i & mask) * MixC1;
    entry_d.count = count;
    entry_d.last  = last_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mmh3_queue.sv
// Two-entry queue that decouples the front part from the back part.
`default_nettype none
module mmh3_queue import mmh3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire mmh3_entry_t entry_i,
  input  wire logic        pop_i,
  output mmh3_entry_t      entry_o,
  output mmh3_q_stat_t     stat_o
);

  mmh3_entry_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mmh3_back.sv
// Back part: completes the word mix, updates the running hash and finalizes each key.
`default_nettype none
module mmh3_back import mmh3_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire mmh3_entry_t  q_entry_i,
  input  wire mmh3_q_stat_t q_stat_i,
  output logic              q_pop_o,
  output logic [31:0]       hash_o,
  output logic              empty,
  input  wire logic         pop
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StUpd  = 3'd1;
  localparam logic [2:0] StFin1 = 3'd2;
  localparam logic [2:0] StFin2 = 3'd3;
  localparam logic [2:0] StFin3 = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [31:0]           seed_q;
  logic [31:0]           run_q, run_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [31:0]           k_q, k_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  last_q, last_d;
  logic [31:0]           f_q, f_d;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_q, out_d;
  logic                  out_free;
  logic [31:0]           h_mix;
  logic [31:0]           h_rot;
  logic [LengthBits-1:0] len_sum;

  assign empty    = !out_valid_q;
  assign hash_o   = out_q;
  assign out_free = !out_valid_q || pop;
  assign q_pop_o  = (state_q == StIdle) && !q_stat_i.empty;

  // Running hash update for the word held in k_q.
  always_comb begin
    h_mix   = run_q ^ ((cnt_q != 3'd0) ? k_q : 32'h0);
    h_rot   = rotl13(h_mix);
    len_sum = len_q + LengthBits'(cnt_q);
  end

  // Sequencer: pop, update, then three finalizer steps on a last word.
  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    len_d       = len_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    f_d         = f_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    case (state_q)
      StIdle: begin
        if (q_pop_o) begin
          k_d     = rotl15(q_entry_i.k1) * MixC2;
          cnt_d   = q_entry_i.count;
          last_d  = q_entry_i.last;
          state_d = StUpd;
        end
      end
      StUpd: begin
        if (cnt_q == FullCount) begin
          f_d = {h_rot[29:0], 2'b00} + h_rot + MixC3;
        end else begin
          f_d = h_mix;
        end
        if (last_q) begin
          f_d     = f_d ^ 32'(len_sum);
          run_d   = seed_q;
          len_d   = '0;
          state_d = StFin1;
        end else begin
          run_d   = f_d;
          len_d   = len_sum;
          state_d = StIdle;
        end
      end
      StFin1: begin
        f_d     = (f_q ^ {16'h0, f_q[31:16]}) * FinC1;
        state_d = StFin2;
      end
      StFin2: begin
        f_d     = (f_q ^ {13'h0, f_q[31:13]}) * FinC2;
        state_d = StFin3;
      end
      StFin3: begin
        if (out_free) begin
          out_d       = f_q ^ {16'h0, f_q[31:16]};
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // A seed write restarts the key.
    if (cfg_we_i) begin
      run_d = cfg_wdata_i;
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seed_q      <= SeedReset;
      run_q       <= SeedReset;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    f_q    <= f_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/murmur3_32_key_hash.sv
// Top level of the streaming 32-bit MurmurHash3 key hash.
//
// Key words enter through a queue-style port: a word is taken at a clock edge
// with push high and full low. Each word carries up to four little-endian key
// bytes, a byte count and a last flag; words before the last one count as four
// bytes. On each last word one hash appears on hash_o while empty is low and is
// taken at an edge with pop high. The seed is written through cfg_we_i and
// cfg_wdata_i; a write also restarts the key in progress.
// Back sequencer: a non-last word takes the pop state (with the second multiply)
// and the hash update; a last word adds the two finalizer multiply states and
// the output load. A new word is popped only from the idle state. The front
// stage and the two-entry queue absorb words while the back part works.
// An accepted last word passes the front stage, the queue, and the pop, update,
// finalizer and output load states before empty goes low.
// Reset loads the default seed, clears the key length and empties all stages.
// While the receiver stalls, one hash waits in the output register, the back
// part finishes the next key up to the output and then holds, and full rises
// once the queue and the front stage are occupied.
`default_nettype none
module murmur3_32_key_hash import mmh3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_i,
  input  wire logic        push,
  output logic             full,
  output logic [31:0]      hash_o,
  output logic             empty,
  input  wire logic        pop,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  mmh3_entry_t  f_entry;
  mmh3_entry_t  q_entry;
  mmh3_q_stat_t q_stat;
  logic         q_push;
  logic         q_pop;

  mmh3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .push         (push),
    .full         (full),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_entry_o    (f_entry)
  );

  mmh3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (f_entry),
    .pop_i   (q_pop),
    .entry_o (q_entry),
    .stat_o  (q_stat)
  );

  mmh3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_entry_i   (q_entry),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .hash_o      (hash_o),
    .empty       (empty),
    .pop         (pop)
  );

`ifndef SYNTHESIS
  // The front stage never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // The back part never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // Backpressure reaches the input only when the queue is full.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_stat.full)
    else $error("full raised with room in the queue");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench of the streaming MurmurHash3 key hash.
`timescale 1ns / 100ps

module testbench;

  // Hash constants of the 32-bit variant.
  localparam logic [31:0] DefaultSeed = 32'h238F13AF;
  localparam logic [31:0] BlockMulA   = 32'hcc9e2d51;
  localparam logic [31:0] BlockMulB   = 32'h1b873593;
  localparam logic [31:0] HashAddend  = 32'he6546b64;
  localparam logic [31:0] AvalMulA    = 32'h85ebca6b;
  localparam logic [31:0] AvalMulB    = 32'hc2b2ae35;
  localparam logic [2:0]  WordBytes   = 3'd4;

  // Cycles the block may still be busy after the last hash has come out.
  localparam int DrainCycles   = 24;
  // Cycles without any accepted word, hash or seed write before giving up.
  localparam int WatchdogLimit = 2000;
  localparam int RandomWords   = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] data_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] hash_o;
  logic        empty;
  logic        pop = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  // Predictor state.
  logic [31:0] hash_seed = DefaultSeed;
  logic [31:0] run_hash = DefaultSeed;
  logic [31:0] key_bytes = '0;
  logic [31:0] expected_hashes[$];

  int  err_count = 0;
  int  words_sent = 0;
  int  stall_cycles = 0;
  int  pop_hold = 0;
  bit  push_gaps_on = 1'b1;
  bit  pop_gaps_on = 1'b1;

  murmur3_32_key_hash DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_word_i (data_word_i),
    .byte_count_i(byte_count_i),
    .last_i      (last_i),
    .push        (push),
    .full        (full),
    .hash_o      (hash_o),
    .empty       (empty),
    .pop         (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Block scramble applied to every key word that holds at least one byte.
  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * BlockMulA;
    t = rol32(t, 15);
    t = t * BlockMulB;
    return t;
  endfunction

  // Final avalanche of the hash.
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * AvalMulA;
    t = t ^ (t >> 13);
    t = t * AvalMulB;
    t = t ^ (t >> 16);
    return t;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Folds one accepted word into the predicted hash state.
  task automatic absorb_word(input logic [31:0] w, input logic [2:0] cnt, input logic is_last);
    logic [31:0] h;
    logic [31:0] nbytes;
    logic [31:0] keep;
    h = run_hash;
    nbytes = (!is_last || cnt >= WordBytes) ? 32'd4 : 32'(cnt);
    if (nbytes == 32'd4) begin
      h = h ^ scramble_block(w);
      h = rol32(h, 13);
      h = h * 32'd5 + HashAddend;
    end else if (nbytes != 0) begin
      keep = (32'h1 << (8 * nbytes)) - 32'h1;
      h = h ^ scramble_block(w & keep);
    end
    key_bytes = key_bytes + nbytes;
    if (!is_last) begin
      run_hash = h;
    end else begin
      expected_hashes.push_back(avalanche(h ^ key_bytes));
      run_hash = hash_seed;
      key_bytes = '0;
    end
  endtask

  // Offers one word and returns at the edge that accepts it.
  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic is_last);
    int gap;
    gap = pick_gap(push_gaps_on);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    data_word_i <= w;
    byte_count_i <= cnt;
    last_i <= is_last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    absorb_word(w, cnt, is_last);
    words_sent++;
  endtask

  // Waits until every hash has come out and the block has settled.
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes the seed; the block must be idle.
  task automatic write_seed(input logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hash_seed = value;
    run_hash = value;
    key_bytes = '0;
  endtask

  function automatic logic [31:0] random_data();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Sends a key of full words followed by a last word with the given count.
  task automatic send_key(input int n_full, input logic [2:0] tail_count);
    for (int i = 0; i < n_full; i++) send_word(random_data(), WordBytes, 1'b0);
    send_word(random_data(), tail_count, 1'b1);
  endtask

  // Short keys, partial tails, oversize counts and ignored counts on
  // non-last words, all with the default seed.
  task automatic test_directed_keys();
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'hA5A5_1234, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
    send_word(32'h1357_9BDF, 3'd6, 1'b1);
    send_word(32'h8000_0001, 3'd7, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
    send_word(32'h1234_5678, 3'd3, 1'b1);
    send_word(32'hDEAD_BEEF, 3'd0, 1'b0);
    send_word(32'h0F0F_0F0F, 3'd7, 1'b0);
    send_word(32'hF0F0_F0F0, 3'd2, 1'b0);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    wait_idle();
  endtask

  // Seed extremes and a seed write that abandons a key in progress.
  task automatic test_seed_writes();
    write_seed(32'h0000_0000);
    send_key(1, 3'd2);
    wait_idle();
    write_seed(32'hFFFF_FFFF);
    send_key(1, 3'd4);
    wait_idle();
    // Partial key left behind by the seed write must not affect the next key.
    send_word(32'hCAFE_F00D, WordBytes, 1'b0);
    send_word(32'h0BAD_CAFE, WordBytes, 1'b0);
    wait_idle();
    write_seed($urandom);
    send_key(0, 3'd3);
    wait_idle();
    write_seed(DefaultSeed);
  endtask

  // Mostly well-formed keys with random content, some noisy or abandoned,
  // in phases with different idling and seeds.
  task automatic test_random_keys();
    int start;
    int phase_end;
    int r;
    int n_full;
    logic [2:0] tail;
    start = words_sent;
    phase_end = words_sent + 250;
    while (words_sent - start < RandomWords) begin
      r = $urandom_range(0, 99);
      n_full = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
      tail = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (r < 80) begin
        send_key(n_full, tail);
      end else if (r < 92) begin
        // Byte counts on non-last words are ignored.
        for (int i = 0; i < n_full + 1; i++) send_word(random_data(), 3'($urandom), 1'b0);
        send_word(random_data(), 3'($urandom), 1'b1);
      end else begin
        // Start a key, then drop it with a seed write.
        for (int i = 0; i < n_full + 1; i++) send_word(random_data(), WordBytes, 1'b0);
        wait_idle();
        write_seed(random_data());
      end
      if (words_sent >= phase_end) begin
        phase_end = words_sent + 250;
        wait_idle();
        r = $urandom_range(0, 3);
        push_gaps_on = (r != 0) && (r != 1);
        pop_gaps_on = (r != 0) && (r != 2);
        write_seed(random_data());
      end
    end
    push_gaps_on = 1'b1;
    pop_gaps_on = 1'b1;
  endtask

  // Receiver side: pop with random stalls after each accepted hash.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) pop_hold = pick_gap(pop_gaps_on);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compare each accepted hash with the oldest expectation.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && pop && !empty) begin
      if (expected_hashes.size() == 0) begin
        $error("hash: unexpected result, actual %h", hash_o);
        err_count++;
      end else begin
        want = expected_hashes.pop_front();
        if (hash_o !== want) begin
          $error("hash: expected %h, actual %h", want, hash_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word, hash or seed write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_keys();
    test_seed_writes();
    test_random_keys();
    wait_idle();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mmh3_pkg.sv
hw/rtl/mmh3_front.sv
hw/rtl/mmh3_queue.sv
hw/rtl/mmh3_back.sv
hw/rtl/murmur3_32_key_hash.sv
verif/testbench.sv
